[sv/trf_pkg.sv]
// Shared constants, command and status codes, and the edge function of the rasterizer.
package trf_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 24;
  localparam int CH_W      = 8;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DIF_W  = COORD_W + 2;
  localparam int BOX_W  = COORD_W + 2;
  localparam int EW     = 2 * DIF_W + 2;
  localparam int NUM_W  = EW + CH_W;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 8'd120;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 8'd90;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CULLED  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_READ_OK = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd3;

  // Edge function of directed edge A->B evaluated at point P.
  function automatic logic signed [EW-1:0] edge_fn(
    input logic signed [DIF_W-1:0] ax, input logic signed [DIF_W-1:0] ay,
    input logic signed [DIF_W-1:0] bx, input logic signed [DIF_W-1:0] by,
    input logic signed [DIF_W-1:0] px, input logic signed [DIF_W-1:0] py);
    logic signed [DIF_W-1:0]   ex, ey, qx, qy;
    logic signed [2*DIF_W-1:0] p1, p2;
    ex = bx - ax;
    ey = by - ay;
    qx = px - ax;
    qy = py - ay;
    p1 = ex * qy;
    p2 = ey * qx;
    return EW'(p1) - EW'(p2);
  endfunction

endpackage

[sv/trf_if.sv]
// Command and response channel interfaces of the rasterizer.
interface trf_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic        [trf_pkg::CMD_W-1:0]     command;
  logic signed [trf_pkg::COORD_W-1:0]   vertex_a_x;
  logic signed [trf_pkg::COORD_W-1:0]   vertex_a_y;
  logic signed [trf_pkg::COORD_W-1:0]   vertex_b_x;
  logic signed [trf_pkg::COORD_W-1:0]   vertex_b_y;
  logic signed [trf_pkg::COORD_W-1:0]   vertex_c_x;
  logic signed [trf_pkg::COORD_W-1:0]   vertex_c_y;
  logic        [trf_pkg::COLOR_W-1:0]   color_a;
  logic        [trf_pkg::COLOR_W-1:0]   color_b;
  logic        [trf_pkg::COLOR_W-1:0]   color_c;

  modport source (output valid, command, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, color_a, color_b, color_c, input ready);
  modport sink   (input valid, command, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, color_a, color_b, color_c, output ready);
endinterface

interface trf_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [trf_pkg::STAT_W-1:0]     status;
  logic [trf_pkg::COLOR_W-1:0]    read_color;

  modport source (output valid, status, read_color, input ready);
  modport sink   (input valid, status, read_color, output ready);
endinterface

[sv/triangle_raster_framebuffer.sv]
// Frame-store triangle rasterizer with barycentric color fill and pixel read-back.
//
//   channel   direction  handshake           payload
//   in_cmd    in         valid/ready         command, three vertices, three colors
//   out_rsp   out        valid/ready         status, read_color
//   cfg_*     in         write enable only   screen_width, screen_height
//
// One item is worked on at a time; the response register lets the next item in while
// the previous response still waits. A clear makes one frame-store write per cycle. A
// draw runs its edge setup, then tests each box pixel; a pixel inside the triangle
// runs three channels, each a multiply and an 8-step restoring divide through one
// shared divider, and is then written. The response is posted last. A read steps
// through S_RD_ADDR, S_RD_MEM and S_RD_WAIT for the registered frame-store read port.
// Reset is synchronous and clears the control state only; the frame store holds
// garbage until cleared.
module triangle_raster_framebuffer (
  input  logic                          clk,
  input  logic                          rst_n,
  trf_cmd_if.sink                       in_cmd,
  trf_rsp_if.source                     out_rsp,
  input  logic                          cfg_we,
  input  logic [trf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trf_pkg::CFG_W-1:0]     cfg_data
);
  import trf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SETUP, S_PIX, S_MUL, S_DIV, S_WRITE, S_ADV,
    S_RD_ADDR, S_RD_MEM, S_RD_WAIT, S_RESP
  } state_t;

  localparam int WA = 0;
  localparam int WB = 1;
  localparam int WC = 2;

  state_t state_r;

  logic [CFG_W-1:0] cfg_w_r, cfg_h_r;

  // Latched command.
  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [COLOR_W-1:0]        ca_r, cb_r, cc_r;

  // Bounding box and walk position.
  logic [XW-1:0]     left_r, right_r, x_r;
  logic [YW-1:0]     top_r, bottom_r, y_r;
  logic              box_empty_r;
  logic [ADDR_W-1:0] row_base_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CNT_W-1:0]  clr_n_r;

  logic [1:0]                 setup_step_r;
  logic signed [EW-1:0]       area_r;
  logic signed [EW-1:0]       wt_r  [3];
  logic signed [EW-1:0]       row_r [3];

  // Blend and divider.
  logic [1:0]              ch_r;
  logic [NUM_W-1:0]        num_r, div_r;
  logic [CH_W-1:0]         q_r;
  logic [$clog2(CH_W)-1:0] div_cnt_r;
  logic [CH_W-1:0]         col_r [3];

  // Response.
  logic [STAT_W-1:0]  resp_stat_r;
  logic [COLOR_W-1:0] resp_col_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_stat_r;
  logic [COLOR_W-1:0] out_col_r;

  // Frame store.
  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;

  // Effective screen size, saturated to the frame store's dimensions.
  logic [WD_W-1:0] w_eff;
  logic [HD_W-1:0] h_eff;
  assign w_eff = ({8'b0, cfg_w_r} > 16'(MAX_WIDTH))  ? WD_W'(MAX_WIDTH)  : WD_W'(cfg_w_r);
  assign h_eff = ({8'b0, cfg_h_r} > 16'(MAX_HEIGHT)) ? HD_W'(MAX_HEIGHT) : HD_W'(cfg_h_r);

  logic signed [BOX_W-1:0] w_s, h_s;
  assign w_s = $signed({{(BOX_W-WD_W){1'b0}}, w_eff});
  assign h_s = $signed({{(BOX_W-HD_W){1'b0}}, h_eff});

  // Bounding box of the incoming triangle, clipped to the screen.
  logic signed [BOX_W-1:0] iax, iay, ibx, iby, icx, icy;
  logic signed [BOX_W-1:0] mnx, mxx, mny, mxy, bl, br, bt, bb;
  assign iax = BOX_W'(in_cmd.vertex_a_x);
  assign iay = BOX_W'(in_cmd.vertex_a_y);
  assign ibx = BOX_W'(in_cmd.vertex_b_x);
  assign iby = BOX_W'(in_cmd.vertex_b_y);
  assign icx = BOX_W'(in_cmd.vertex_c_x);
  assign icy = BOX_W'(in_cmd.vertex_c_y);

  always_comb begin
    mnx = (iax < ibx) ? iax : ibx;
    mnx = (mnx < icx) ? mnx : icx;
    mxx = (iax > ibx) ? iax : ibx;
    mxx = (mxx > icx) ? mxx : icx;
    mny = (iay < iby) ? iay : iby;
    mny = (mny < icy) ? mny : icy;
    mxy = (iay > iby) ? iay : iby;
    mxy = (mxy > icy) ? mxy : icy;
    bl  = (mnx < 0) ? '0 : mnx;
    bt  = (mny < 0) ? '0 : mny;
    br  = (mxx > w_s - 1) ? w_s - 1 : mxx;
    bb  = (mxy > h_s - 1) ? h_s - 1 : mxy;
  end

  logic rd_outside;
  assign rd_outside = (iax < 0) || (iay < 0) || (iax >= w_s) || (iay >= h_s);

  logic [WD_W+HD_W-1:0] clr_prod;
  assign clr_prod = w_eff * h_eff;

  logic [YW+WD_W-1:0] top_prod, rd_prod;
  assign top_prod = top_r * w_eff;
  assign rd_prod  = y_r * w_eff;

  // Shared edge unit: the area first, then edges A->B, B->C and C->A at the box corner.
  logic signed [DIF_W-1:0] dax, day, dbx, dby, dcx, dcy, plx, pty;
  logic signed [DIF_W-1:0] e_ax, e_ay, e_bx, e_by, e_px, e_py;
  logic signed [EW-1:0]    e_val;
  assign dax = DIF_W'(ax_r);
  assign day = DIF_W'(ay_r);
  assign dbx = DIF_W'(bx_r);
  assign dby = DIF_W'(by_r);
  assign dcx = DIF_W'(cx_r);
  assign dcy = DIF_W'(cy_r);
  assign plx = $signed({{(DIF_W-XW){1'b0}}, left_r});
  assign pty = $signed({{(DIF_W-YW){1'b0}}, top_r});

  always_comb begin
    case (setup_step_r)
      2'd0: begin
        e_ax = dax; e_ay = day; e_bx = dbx; e_by = dby; e_px = dcx; e_py = dcy;
      end
      2'd1: begin
        e_ax = dax; e_ay = day; e_bx = dbx; e_by = dby; e_px = plx; e_py = pty;
      end
      2'd2: begin
        e_ax = dbx; e_ay = dby; e_bx = dcx; e_by = dcy; e_px = plx; e_py = pty;
      end
      default: begin
        e_ax = dcx; e_ay = dcy; e_bx = dax; e_by = day; e_px = plx; e_py = pty;
      end
    endcase
    e_val = edge_fn(e_ax, e_ay, e_bx, e_by, e_px, e_py);
  end

  // Per-pixel steps of each edge function along x and y.
  logic signed [DIF_W-1:0] stx [3];
  logic signed [DIF_W-1:0] sty [3];
  assign stx[WC] = day - dby;
  assign sty[WC] = dbx - dax;
  assign stx[WA] = dby - dcy;
  assign sty[WA] = dcx - dbx;
  assign stx[WB] = dcy - day;
  assign sty[WB] = dax - dcx;

  logic in_tri;
  assign in_tri = !wt_r[WA][EW-1] && !wt_r[WB][EW-1] && !wt_r[WC][EW-1];

  // Channel numerator: sum of vertex channel values weighted by the edge functions.
  logic [CH_W-1:0]        ch_a, ch_b, ch_c;
  logic [CH_W+EW-2:0]     pa, pb, pc;
  logic [NUM_W-1:0]       num_sum;
  always_comb begin
    case (ch_r)
      2'd0: begin
        ch_a = ca_r[23:16]; ch_b = cb_r[23:16]; ch_c = cc_r[23:16];
      end
      2'd1: begin
        ch_a = ca_r[15:8]; ch_b = cb_r[15:8]; ch_c = cc_r[15:8];
      end
      default: begin
        ch_a = ca_r[7:0]; ch_b = cb_r[7:0]; ch_c = cc_r[7:0];
      end
    endcase
    pa = ch_a * wt_r[WA][EW-2:0];
    pb = ch_b * wt_r[WB][EW-2:0];
    pc = ch_c * wt_r[WC][EW-2:0];
    num_sum = NUM_W'(pa) + NUM_W'(pb) + NUM_W'(pc);
  end

  logic            div_ge;
  logic [CH_W-1:0] q_fin;
  assign div_ge = (num_r >= div_r);
  assign q_fin  = {q_r[CH_W-2:0], div_ge};

  // Frame store write port.
  always_comb begin
    mem_we    = (state_r == S_CLEAR) || (state_r == S_WRITE);
    mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : row_base_r + ADDR_W'(x_r);
    mem_wdata = (state_r == S_CLEAR) ? ca_r : {col_r[0], col_r[1], col_r[2]};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  assign in_cmd.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_stat_r;
  assign out_rsp.read_color = out_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_w_r     <= SCREEN_WIDTH_RST;
      cfg_h_r     <= SCREEN_HEIGHT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  cfg_w_r <= cfg_data;
          REG_SCREEN_HEIGHT: cfg_h_r <= cfg_data;
          default: ;
        endcase
      end

      // The response state reloads the output register itself.
      if (out_valid_r && out_rsp.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_cmd.valid) begin
            ax_r        <= in_cmd.vertex_a_x;
            ay_r        <= in_cmd.vertex_a_y;
            bx_r        <= in_cmd.vertex_b_x;
            by_r        <= in_cmd.vertex_b_y;
            cx_r        <= in_cmd.vertex_c_x;
            cy_r        <= in_cmd.vertex_c_y;
            ca_r        <= in_cmd.color_a;
            cb_r        <= in_cmd.color_b;
            cc_r        <= in_cmd.color_c;
            left_r      <= XW'(bl);
            right_r     <= XW'(br);
            top_r       <= YW'(bt);
            bottom_r    <= YW'(bb);
            box_empty_r <= (bl > br) || (bt > bb);
            clr_n_r     <= CNT_W'(clr_prod);
            clr_addr_r  <= '0;
            setup_step_r <= 2'd0;
            x_r         <= XW'(iax);
            y_r         <= YW'(iay);
            resp_stat_r <= ((in_cmd.command == CMD_READ) && rd_outside) ? STAT_OUTSIDE
                                                                          : STAT_DONE;
            resp_col_r  <= '0;
            case (in_cmd.command)
              CMD_CLEAR: state_r <= (clr_prod == '0) ? S_RESP : S_CLEAR;
              CMD_DRAW:  state_r <= S_SETUP;
              CMD_READ:  state_r <= rd_outside ? S_RESP : S_RD_ADDR;
              default:   state_r <= S_RESP;
            endcase
          end
        end

        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if ({1'b0, clr_addr_r} == clr_n_r - 1'b1) begin
            state_r <= S_RESP;
          end
        end

        S_SETUP: begin
          setup_step_r <= setup_step_r + 1'b1;
          case (setup_step_r)
            2'd0: begin
              area_r     <= e_val;
              row_base_r <= ADDR_W'(top_prod);
              if (e_val <= 0) begin
                resp_stat_r <= STAT_CULLED;
                state_r     <= S_RESP;
              end else if (box_empty_r) begin
                state_r <= S_RESP;
              end
            end
            2'd1: begin
              wt_r[WC]  <= e_val;
              row_r[WC] <= e_val;
            end
            2'd2: begin
              wt_r[WA]  <= e_val;
              row_r[WA] <= e_val;
            end
            default: begin
              wt_r[WB]  <= e_val;
              row_r[WB] <= e_val;
              x_r       <= left_r;
              y_r       <= top_r;
              state_r   <= S_PIX;
            end
          endcase
        end

        S_PIX: begin
          ch_r    <= 2'd0;
          state_r <= in_tri ? S_MUL : S_ADV;
        end

        S_MUL: begin
          num_r     <= num_sum;
          div_r     <= NUM_W'(area_r[EW-2:0]) << (CH_W - 1);
          q_r       <= '0;
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end

        // Restoring divide; the quotient never exceeds one channel's range.
        S_DIV: begin
          if (div_ge) begin
            num_r <= num_r - div_r;
          end
          div_r     <= div_r >> 1;
          q_r       <= q_fin;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == $clog2(CH_W)'(CH_W - 1)) begin
            col_r[ch_r] <= q_fin;
            if (ch_r == 2'd2) begin
              state_r <= S_WRITE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_MUL;
            end
          end
        end

        S_WRITE: begin
          state_r <= S_ADV;
        end

        S_ADV: begin
          if (x_r == right_r) begin
            if (y_r == bottom_r) begin
              state_r <= S_RESP;
            end else begin
              y_r        <= y_r + 1'b1;
              x_r        <= left_r;
              row_base_r <= row_base_r + ADDR_W'(w_eff);
              for (int i = 0; i < 3; i++) begin
                row_r[i] <= row_r[i] + EW'(sty[i]);
                wt_r[i]  <= row_r[i] + EW'(sty[i]);
              end
              state_r <= S_PIX;
            end
          end else begin
            x_r <= x_r + 1'b1;
            for (int i = 0; i < 3; i++) begin
              wt_r[i] <= wt_r[i] + EW'(stx[i]);
            end
            state_r <= S_PIX;
          end
        end

        S_RD_ADDR: begin
          rd_addr_r <= ADDR_W'(rd_prod) + ADDR_W'(x_r);
          state_r   <= S_RD_MEM;
        end

        S_RD_MEM: begin
          state_r <= S_RD_WAIT;
        end

        S_RD_WAIT: begin
          resp_stat_r <= STAT_READ_OK;
          resp_col_r  <= rd_data_r;
          state_r     <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r <= 1'b1;
            out_stat_r  <= resp_stat_r;
            out_col_r   <= resp_col_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[verif/tb.sv]
// Self-checking testbench of the triangle rasterizer: directed and random commands.
module tb;
  import trf_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The slowest
  // single item is a draw that fills a saturated 128x128 frame.
  localparam int HANG_LIMIT = 2000000;

  typedef struct {
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
    logic [COLOR_W-1:0]        ca, cb, cc;
  } raster_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [COLOR_W-1:0] color;
  } raster_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  trf_cmd_if in_cmd ();
  trf_rsp_if out_rsp ();

  triangle_raster_framebuffer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (in_cmd.sink),
    .out_rsp   (out_rsp.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the frame store and of the screen registers.
  logic [COLOR_W-1:0] shadow_frame [DEPTH];
  logic [CFG_W-1:0]   shadow_width;
  logic [CFG_W-1:0]   shadow_height;

  raster_rsp_t pending_rsp_q [$];
  int  error_count;
  int  hang_count;
  // When set, neither side idles; used for a long back-to-back stretch.
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int active_width();
    return (shadow_width > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_width);
  endfunction

  function automatic int active_height();
    return (shadow_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_height);
  endfunction

  // Signed area spanned by the edge a->b and the point p.
  function automatic longint edge_area(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  // One color channel weighted by the three barycentric weights, truncated.
  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                             longint wa, longint wb, longint wc,
                                             longint area);
    longint v;
    v = (longint'(a) * wa + longint'(b) * wb + longint'(c) * wc) / area;
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    return v[7:0];
  endfunction

  // Applies one command to the shadow frame and returns the response it yields.
  function automatic raster_rsp_t raster_predict(raster_cmd_t c);
    raster_rsp_t r;
    int w, h, left, right, top, bottom;
    longint area, wa, wb, wc;
    w = active_width();
    h = active_height();
    r.status = STAT_DONE;
    r.color  = '0;
    case (c.command)
      CMD_CLEAR: begin
        for (int i = 0; i < w * h; i++) shadow_frame[i] = c.ca;
      end
      CMD_DRAW: begin
        area = edge_area(c.ax, c.ay, c.bx, c.by, c.cx, c.cy);
        if (area <= 0) begin
          r.status = STAT_CULLED;
        end else begin
          left   = int'(c.ax); if (c.bx < left) left = c.bx; if (c.cx < left) left = c.cx;
          right  = int'(c.ax); if (c.bx > right) right = c.bx; if (c.cx > right) right = c.cx;
          top    = int'(c.ay); if (c.by < top) top = c.by; if (c.cy < top) top = c.cy;
          bottom = int'(c.ay); if (c.by > bottom) bottom = c.by;
          if (c.cy > bottom) bottom = c.cy;
          if (left < 0) left = 0;
          if (top < 0) top = 0;
          if (right > w - 1) right = w - 1;
          if (bottom > h - 1) bottom = h - 1;
          for (int y = top; y <= bottom; y++) begin
            for (int x = left; x <= right; x++) begin
              wc = edge_area(c.ax, c.ay, c.bx, c.by, x, y);
              wa = edge_area(c.bx, c.by, c.cx, c.cy, x, y);
              wb = edge_area(c.cx, c.cy, c.ax, c.ay, x, y);
              if (wa >= 0 && wb >= 0 && wc >= 0) begin
                shadow_frame[y * w + x] = {
                  mix_channel(c.ca[23:16], c.cb[23:16], c.cc[23:16], wa, wb, wc, area),
                  mix_channel(c.ca[15:8],  c.cb[15:8],  c.cc[15:8],  wa, wb, wc, area),
                  mix_channel(c.ca[7:0],   c.cb[7:0],   c.cc[7:0],   wa, wb, wc, area)};
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (c.ax < 0 || c.ay < 0 || c.ax >= w || c.ay >= h) begin
          r.status = STAT_OUTSIDE;
        end else begin
          r.status = STAT_READ_OK;
          r.color  = shadow_frame[int'(c.ay) * w + int'(c.ax)];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one item, waits for it to be taken, then records its expected response.
  task automatic send_item(raster_cmd_t c);
    int gap;
    gap = (calm || $urandom_range(99) >= 28) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      in_cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd.valid      <= 1'b1;
    in_cmd.command    <= c.command;
    in_cmd.vertex_a_x <= c.ax;
    in_cmd.vertex_a_y <= c.ay;
    in_cmd.vertex_b_x <= c.bx;
    in_cmd.vertex_b_y <= c.by;
    in_cmd.vertex_c_x <= c.cx;
    in_cmd.vertex_c_y <= c.cy;
    in_cmd.color_a    <= c.ca;
    in_cmd.color_b    <= c.cb;
    in_cmd.color_c    <= c.cc;
    do @(posedge clk); while (!in_cmd.ready);
    pending_rsp_q.push_back(raster_predict(c));
  endtask

  // Drops valid and waits until every outstanding response has come back.
  task automatic drain();
    in_cmd.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers are only written while the block is idle.
  task automatic set_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_width  = w;
    shadow_height = h;
  endtask

  function automatic raster_cmd_t make_cmd(logic [CMD_W-1:0] op, int ax, int ay, int bx,
                                           int by, int cx, int cy, logic [23:0] ca,
                                           logic [23:0] cb, logic [23:0] cc);
    raster_cmd_t c;
    c.command = op;
    c.ax = ax; c.ay = ay; c.bx = bx; c.by = by; c.cx = cx; c.cy = cy;
    c.ca = ca; c.cb = cb; c.cc = cc;
    return c;
  endfunction

  task automatic send_read(int x, int y);
    send_item(make_cmd(CMD_READ, x, y, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Reset values of the screen registers, culling and the unused command code.
  task automatic test_default_screen();
    send_item(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'h123456, 0, 0));
    send_read(0, 0);
    send_read(119, 89);
    send_read(120, 0);
    send_read(0, 90);
    send_read(-1, 5);
    send_item(make_cmd(CMD_DRAW, 10, 10, 30, 12, 14, 28, 24'hFF0000, 24'h00FF00, 24'h0000FF));
    send_read(15, 15);
    send_read(20, 14);
    // Back-facing winding and a degenerate (collinear) triangle are both culled.
    send_item(make_cmd(CMD_DRAW, 10, 10, 14, 28, 30, 12, 24'hFFFFFF, 0, 0));
    send_item(make_cmd(CMD_DRAW, 0, 0, 5, 5, 10, 10, 24'hFFFFFF, 0, 0));
    send_item(make_cmd(2'd3, 1, 2, 3, 4, 5, 6, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_read(15, 15);
  endtask

  // Extreme coordinates and colors on a small screen, then extreme screen sizes.
  task automatic test_extremes();
    set_screen(8'd16, 8'd12);
    send_item(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0, 0));
    send_item(make_cmd(CMD_DRAW, -2048, -2048, 2047, -2048, -2048, 2047,
                       24'hFFFFFF, 24'h000000, 24'h00FF00));
    send_read(0, 0);
    send_read(15, 11);
    send_read(2047, 2047);
    send_read(-2048, -2048);
    // A zero-sized screen has no active pixel at all.
    set_screen(8'd0, 8'd0);
    send_item(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'hABCDEF, 0, 0));
    send_item(make_cmd(CMD_DRAW, 0, 0, 4, 0, 0, 4, 24'hFFFFFF, 0, 0));
    send_read(0, 0);
    set_screen(8'd1, 8'd1);
    send_item(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'h000000, 0, 0));
    send_item(make_cmd(CMD_DRAW, 0, 0, 3, 0, 0, 3, 24'h0F0F0F, 24'hF0F0F0, 24'h55AA55));
    send_read(0, 0);
    send_read(1, 0);
    // An oversized width and height saturate to the largest frame.
    set_screen(8'd255, 8'd255);
    send_item(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'h808080, 0, 0));
    send_item(make_cmd(CMD_DRAW, 120, 120, 140, 122, 121, 140, 24'hFFFFFF, 0, 24'hFFFFFF));
    send_read(127, 127);
    send_read(128, 0);
  endtask

  function automatic raster_cmd_t random_cmd();
    raster_cmd_t c;
    int w, h, pick, bx0, by0;
    w = active_width();
    h = active_height();
    pick = $urandom_range(99);
    c.ca = $urandom; c.cb = $urandom; c.cc = $urandom;
    c.ax = $urandom; c.ay = $urandom; c.bx = $urandom;
    c.by = $urandom; c.cx = $urandom; c.cy = $urandom;
    if (pick < 3) begin
      c.command = CMD_CLEAR;
    end else if (pick < 5) begin
      c.command = 2'd3;
    end else if (pick < 7) begin
      // Raw triangle: any coordinates, often covering much of the screen.
      c.command = CMD_DRAW;
    end else if (pick < 55) begin
      c.command = CMD_DRAW;
      bx0 = $urandom_range(0, w + 6) - 4;
      by0 = $urandom_range(0, h + 6) - 4;
      c.ax = bx0 + $urandom_range(0, 8); c.ay = by0 + $urandom_range(0, 8);
      c.bx = bx0 + $urandom_range(0, 8); c.by = by0 + $urandom_range(0, 8);
      c.cx = bx0 + $urandom_range(0, 8); c.cy = by0 + $urandom_range(0, 8);
      // Mostly front-facing; the rest stays as drawn and is often culled.
      if ($urandom_range(99) < 85 &&
          edge_area(c.ax, c.ay, c.bx, c.by, c.cx, c.cy) < 0) begin
        {c.bx, c.by, c.cx, c.cy} = {c.cx, c.cy, c.bx, c.by};
      end
    end else begin
      c.command = CMD_READ;
      if (w > 0 && h > 0 && $urandom_range(99) < 85) begin
        c.ax = $urandom_range(0, w - 1);
        c.ay = $urandom_range(0, h - 1);
      end
    end
    return c;
  endfunction

  // Random phases, each on its own screen size and opened by a clear so that
  // every in-screen read hits a written pixel.
  task automatic test_random_phases();
    logic [CFG_W-1:0] w, h;
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 4) begin
        w = 8'd200;
        h = 8'd130;
      end else begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 24);
      end
      set_screen(w, h);
      calm = (phase == 2);
      send_item(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, $urandom, 0, 0));
      for (int n = 0; n < 150; n++) begin
        if (phase == 6 && n == 75) drain();
        send_item(random_cmd());
      end
      calm = 1'b0;
    end
  endtask

  // Response checker, receiver stalls and hang watchdog.
  always @(posedge clk) begin
    raster_rsp_t want;
    if (!rst_n) begin
      hang_count <= 0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: response without a pending item: status %0d color %06h",
                   $time, out_rsp.status, out_rsp.read_color);
          error_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_rsp.status);
            error_count++;
          end
          if (out_rsp.read_color !== want.color) begin
            $display("%0t: read_color expected %06h actual %06h", $time, want.color,
                     out_rsp.read_color);
            error_count++;
          end
        end
      end
      if ((out_rsp.valid && out_rsp.ready) || (in_cmd.valid && in_cmd.ready)) begin
        hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        hang_count <= hang_count + 1;
      end
    end
    out_rsp.ready <= calm || ($urandom_range(99) >= 28);
  end

  initial begin
    error_count = 0;
    calm = 1'b0;
    shadow_width  = SCREEN_WIDTH_RST;
    shadow_height = SCREEN_HEIGHT_RST;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_cmd.valid = 1'b0;
    in_cmd.command = '0;
    in_cmd.vertex_a_x = '0;
    in_cmd.vertex_a_y = '0;
    in_cmd.vertex_b_x = '0;
    in_cmd.vertex_b_y = '0;
    in_cmd.vertex_c_x = '0;
    in_cmd.vertex_c_y = '0;
    in_cmd.color_a = '0;
    in_cmd.color_b = '0;
    in_cmd.color_c = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_screen();
    test_extremes();
    test_random_phases();

    drain();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
